### rtl/sha1md_pkg.sv
// Shared types and constants for the SHA-1 message digest core.
// Holds the sequencer states, block modes, round phases and the SHA-1 constants.
// No dependencies; compile this file first.
`timescale 1ns / 1ps

package sha1md_pkg;

  // Main sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RUN,
    ST_ADD,
    ST_OREAD,
    ST_OLOAD
  } state_t;

  // Kind of block being compressed: plain data, the first padded block or the extra
  // length-only block.
  typedef enum logic [1:0] {
    BLK_DATA,
    BLK_PAD,
    BLK_EXTRA
  } blk_mode_t;

  // Round function groups of twenty rounds each.
  typedef enum logic [1:0] {
    PH_CHOOSE,
    PH_PARITY_LO,
    PH_MAJORITY,
    PH_PARITY_HI
  } phase_t;

  // Working variables of the compression.
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } work_t;

  localparam logic [31:0] K_CHOOSE     = 32'h5a827999;
  localparam logic [31:0] K_PARITY_LO  = 32'h6ed9eba1;
  localparam logic [31:0] K_MAJORITY   = 32'h8f1bbcdc;
  localparam logic [31:0] K_PARITY_HI  = 32'hca62c1d6;
  localparam logic [7:0]  PAD_MARK     = 8'h80;
  localparam logic [6:0]  ROUND_LAST   = 7'd79;
  localparam logic [2:0]  CV_LAST      = 3'd4;

  // Initial chaining value words.
  function automatic logic [31:0] sha1md_iv(input logic [2:0] idx);
    logic [31:0] v;
    case (idx)
      3'd0:    v = 32'h67452301;
      3'd1:    v = 32'hefcdab89;
      3'd2:    v = 32'h98badcfe;
      3'd3:    v = 32'h10325476;
      3'd4:    v = 32'hc3d2e1f0;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

  // Round group for a round number.
  function automatic phase_t sha1md_phase(input logic [6:0] rnd);
    phase_t p;
    if (rnd < 7'd20) begin
      p = PH_CHOOSE;
    end else if (rnd < 7'd40) begin
      p = PH_PARITY_LO;
    end else if (rnd < 7'd60) begin
      p = PH_MAJORITY;
    end else begin
      p = PH_PARITY_HI;
    end
    return p;
  endfunction

endpackage

### rtl/sha1md_if.sv
// Valid/ready channel interfaces for the SHA-1 message digest core.
// One interface for message bytes, one for digest words; no dependencies.
`timescale 1ns / 1ps

interface sha1md_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       last;

  modport source (output valid, output data_byte, output byte_valid, output last,
                  input ready);
  modport sink (input valid, input data_byte, input byte_valid, input last,
                output ready);
endinterface

interface sha1md_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        final_word;

  modport source (output valid, output digest_word, output word_index,
                  output final_word, input ready);
  modport sink (input valid, input digest_word, input word_index, input final_word,
                output ready);
endinterface

### rtl/sha1md_round.sv
// One SHA-1 round: round function, constant add and rotation of the working words.
// Depends on sha1md_pkg.
`timescale 1ns / 1ps

module sha1md_round (
  input  sha1md_pkg::phase_t phase,
  input  sha1md_pkg::work_t  wk_in,
  input  logic [31:0]        w,
  output sha1md_pkg::work_t  wk_out
);
  import sha1md_pkg::*;

  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] t;

  // Round function and constant for the current group.
  always_comb begin
    case (phase)
      PH_CHOOSE: begin
        f = (wk_in.b & wk_in.c) | (~wk_in.b & wk_in.d);
        k = K_CHOOSE;
      end
      PH_PARITY_LO: begin
        f = wk_in.b ^ wk_in.c ^ wk_in.d;
        k = K_PARITY_LO;
      end
      PH_MAJORITY: begin
        f = (wk_in.b & wk_in.c) | (wk_in.b & wk_in.d) | (wk_in.c & wk_in.d);
        k = K_MAJORITY;
      end
      default: begin
        f = wk_in.b ^ wk_in.c ^ wk_in.d;
        k = K_PARITY_HI;
      end
    endcase
  end

  // New a, and the shift of the other words.
  assign t = {wk_in.a[26:0], wk_in.a[31:27]} + f + wk_in.e + k + w;

  assign wk_out.a = t;
  assign wk_out.b = wk_in.a;
  assign wk_out.c = {wk_in.b[1:0], wk_in.b[31:2]};
  assign wk_out.d = wk_in.c;
  assign wk_out.e = wk_in.d;

endmodule

### rtl/sha1_message_digest_core.sv
// SHA-1 message digest core: top level with the block buffer and chaining value memories.
// Depends on sha1md_pkg, sha1md_if and sha1md_round.
`timescale 1ns / 1ps

// Message bytes arrive one word per handshake and are taken only while the core is
// idle. A full 64-byte block is then compressed by reading the chaining value out of
// its memory, running 80 rounds at one round per cycle through the shared round unit,
// and adding the result back into the chaining value memory.
// A word marked last pads the message (one or two more blocks) and then emits the five
// digest words H0 to H4, each read from memory and then loaded into the output register.
// The digest words sit in an output register, so a new message may start while the last
// digest word still waits. The chaining value memory needs no clearing pass: per-entry
// valid bits make unwritten entries read as the SHA-1 initial value, and they are cleared
// when a digest is done.
module sha1_message_digest_core (
  input  logic            clk,
  input  logic            rst_n,
  sha1md_in_if.sink       in_ch,
  sha1md_out_if.source    out_ch
);
  import sha1md_pkg::*;

  // Sequencer and message state.
  state_t      state_r, state_nxt;
  blk_mode_t   mode_r, mode_nxt;
  logic        pend_r, pend_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [60:0] len_r, len_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [6:0]  rnd_r, rnd_nxt;
  logic [2:0]  ci_r, ci_nxt;
  work_t       wk_r, wk_nxt;
  work_t       wk_round;
  logic [31:0] sched_r [16];
  logic [4:0]  cv_vld_r, cv_vld_nxt;

  // Memories and their read registers.
  logic [31:0] blk_mem [16];
  logic [31:0] blk_q_r;
  logic [31:0] cv_mem [5];
  logic [31:0] cv_q_r;
  logic        cv_qv_r;
  logic [2:0]  cv_qidx_r;

  // Output register.
  logic        out_valid_r;
  logic [31:0] out_word_r;
  logic [2:0]  out_idx_r;
  logic        out_final_r;

  // Control strobes.
  logic        in_acc;
  logic        cv_re;
  logic        cv_we;
  logic [2:0]  cv_waddr;
  logic [3:0]  blk_raddr;
  logic        blk_we;
  logic        out_load;
  logic        restart;

  // Datapath values.
  logic [31:0] cv_data;
  logic [31:0] merged;
  logic [4:0]  byte_sh;
  logic [63:0] bit_len;
  logic [31:0] w_block;
  logic [31:0] w_expand;
  logic [31:0] w_cur;

  // Message schedule word for one of the first sixteen rounds: stored data, or padding
  // and length generated on the fly.
  function automatic logic [31:0] pad_word(input logic [3:0] widx, input blk_mode_t mode,
                                           input logic [5:0] fill, input logic [31:0] acc,
                                           input logic [63:0] blen,
                                           input logic [31:0] mem_word);
    logic [31:0] base;
    logic [31:0] v;
    base = (fill[1:0] == 2'd0) ? 32'h0 : acc;
    v    = 32'h0;
    case (mode)
      BLK_DATA: begin
        v = mem_word;
      end
      BLK_PAD: begin
        if (widx < fill[5:2]) begin
          v = mem_word;
        end else if (widx == fill[5:2]) begin
          v = base | ({24'h0, PAD_MARK} << {~fill[1:0], 3'b000});
        end else if (fill < 6'd56 && widx == 4'd14) begin
          v = blen[63:32];
        end else if (fill < 6'd56 && widx == 4'd15) begin
          v = blen[31:0];
        end
      end
      BLK_EXTRA: begin
        if (widx == 4'd14) begin
          v = blen[63:32];
        end else if (widx == 4'd15) begin
          v = blen[31:0];
        end
      end
      default: begin
        v = 32'h0;
      end
    endcase
    return v;
  endfunction

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_ch.last || (in_ch.byte_valid && fill_r == 6'd63))) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (ci_r == 3'd5) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (rnd_r == ROUND_LAST) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        if (ci_r == 3'd5) begin
          case (mode_r)
            BLK_DATA:  state_nxt = pend_r ? ST_LOAD : ST_IDLE;
            BLK_PAD:   state_nxt = (fill_r >= 6'd56) ? ST_LOAD : ST_OREAD;
            default:   state_nxt = ST_OREAD;
          endcase
        end
      end
      ST_OREAD: begin
        state_nxt = ST_OLOAD;
      end
      ST_OLOAD: begin
        if (out_load) begin
          state_nxt = (ci_r == CV_LAST) ? ST_IDLE : ST_OREAD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control strobes from the state.
  always_comb begin
    in_ch.ready = (state_r == ST_IDLE);
    cv_re       = 1'b0;
    cv_we       = 1'b0;
    blk_raddr   = 4'd0;
    out_load    = 1'b0;
    case (state_r)
      ST_LOAD: begin
        cv_re = (ci_r < 3'd5);
      end
      ST_RUN: begin
        blk_raddr = rnd_r[3:0] + 4'd1;
      end
      ST_ADD: begin
        cv_re = (ci_r < 3'd5);
        cv_we = (ci_r != 3'd0);
      end
      ST_OREAD: begin
        cv_re = 1'b1;
      end
      ST_OLOAD: begin
        out_load = !out_valid_r || out_ch.ready;
      end
      default: begin
        cv_re = 1'b0;
      end
    endcase
  end

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign blk_we   = in_acc && in_ch.byte_valid;
  assign cv_waddr = ci_r - 3'd1;
  assign restart  = out_load && (ci_r == CV_LAST);

  // Chaining value read data; entries not yet written read as the initial value.
  assign cv_data = cv_qv_r ? cv_q_r : sha1md_iv(cv_qidx_r);

  // Byte packing, big-endian within each word.
  assign byte_sh = {~fill_r[1:0], 3'b000};
  assign merged  = ((fill_r[1:0] == 2'd0) ? 32'h0 : acc_r) |
                   ({24'h0, in_ch.data_byte} << byte_sh);
  assign bit_len = {len_r, 3'b000};

  // Schedule word for the current round.
  assign w_block  = pad_word(rnd_r[3:0], mode_r, fill_r, acc_r, bit_len, blk_q_r);
  assign w_expand = sched_r[13] ^ sched_r[8] ^ sched_r[2] ^ sched_r[0];
  assign w_cur    = (rnd_r < 7'd16) ? w_block : {w_expand[30:0], w_expand[31]};

  sha1md_round u_round (
    .phase  (sha1md_phase(rnd_r)),
    .wk_in  (wk_r),
    .w      (w_cur),
    .wk_out (wk_round)
  );

  // Next values of the datapath registers.
  always_comb begin
    mode_nxt   = mode_r;
    pend_nxt   = pend_r;
    fill_nxt   = fill_r;
    len_nxt    = len_r;
    acc_nxt    = acc_r;
    rnd_nxt    = rnd_r;
    ci_nxt     = ci_r;
    wk_nxt     = wk_r;
    cv_vld_nxt = cv_vld_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.byte_valid) begin
            acc_nxt  = merged;
            len_nxt  = len_r + 61'd1;
            fill_nxt = fill_r + 6'd1;
          end
          if (in_ch.byte_valid && fill_r == 6'd63) begin
            mode_nxt = BLK_DATA;
            pend_nxt = in_ch.last;
          end else if (in_ch.last) begin
            mode_nxt = BLK_PAD;
          end
        end
      end
      ST_LOAD: begin
        ci_nxt = (ci_r == 3'd5) ? 3'd0 : ci_r + 3'd1;
        if (ci_r != 3'd0) begin
          wk_nxt = '{a: wk_r.b, b: wk_r.c, c: wk_r.d, d: wk_r.e, e: cv_data};
        end
      end
      ST_RUN: begin
        rnd_nxt = (rnd_r == ROUND_LAST) ? 7'd0 : rnd_r + 7'd1;
        wk_nxt  = wk_round;
      end
      ST_ADD: begin
        ci_nxt = (ci_r == 3'd5) ? 3'd0 : ci_r + 3'd1;
        if (ci_r != 3'd0) begin
          wk_nxt = '{a: wk_r.b, b: wk_r.c, c: wk_r.d, d: wk_r.e, e: 32'h0};
          cv_vld_nxt[cv_waddr] = 1'b1;
        end
        if (ci_r == 3'd5) begin
          if (mode_r == BLK_DATA && pend_r) begin
            mode_nxt = BLK_PAD;
            pend_nxt = 1'b0;
          end else if (mode_r == BLK_PAD && fill_r >= 6'd56) begin
            mode_nxt = BLK_EXTRA;
          end
        end
      end
      ST_OLOAD: begin
        if (out_load) begin
          ci_nxt = (ci_r == CV_LAST) ? 3'd0 : ci_r + 3'd1;
        end
        if (restart) begin
          fill_nxt   = 6'd0;
          len_nxt    = 61'd0;
          pend_nxt   = 1'b0;
          cv_vld_nxt = 5'd0;
        end
      end
      default: begin
        ci_nxt = ci_r;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= BLK_DATA;
      pend_r      <= 1'b0;
      fill_r      <= 6'd0;
      len_r       <= 61'd0;
      rnd_r       <= 7'd0;
      ci_r        <= 3'd0;
      cv_vld_r    <= 5'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      mode_r   <= mode_nxt;
      pend_r   <= pend_nxt;
      fill_r   <= fill_nxt;
      len_r    <= len_nxt;
      rnd_r    <= rnd_nxt;
      ci_r     <= ci_nxt;
      cv_vld_r <= cv_vld_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers and the message schedule window.
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    wk_r  <= wk_nxt;
    if (state_r == ST_RUN) begin
      for (int i = 0; i < 15; i++) begin
        sched_r[i] <= sched_r[i + 1];
      end
      sched_r[15] <= w_cur;
    end
    if (out_load) begin
      out_word_r  <= cv_data;
      out_idx_r   <= ci_r;
      out_final_r <= (ci_r == CV_LAST);
    end
  end

  // Block buffer memory: one word written per byte, one word read per cycle.
  always_ff @(posedge clk) begin
    if (blk_we) begin
      blk_mem[fill_r[5:2]] <= merged;
    end
    blk_q_r <= blk_mem[blk_raddr];
  end

  // Chaining value memory: read and write back at different entries in the same cycle.
  always_ff @(posedge clk) begin
    if (cv_we) begin
      cv_mem[cv_waddr] <= cv_data + wk_r.a;
    end
    if (cv_re) begin
      cv_q_r    <= cv_mem[ci_r];
      cv_qv_r   <= cv_vld_r[ci_r];
      cv_qidx_r <= ci_r;
    end
  end

  // Result channel.
  assign out_ch.valid       = out_valid_r;
  assign out_ch.digest_word = out_word_r;
  assign out_ch.word_index  = out_idx_r;
  assign out_ch.final_word  = out_final_r;

endmodule

### tb/sha1_message_digest_core_test.sv
// Self-checking testbench for the SHA-1 message digest core.
// Drives byte words with random gaps and backpressure, predicts each digest in software.
// Depends on sha1md_pkg, sha1md_if and the core RTL.
`timescale 1ns / 1ps

// One expected digest word as it should leave the core.
typedef struct packed {
  bit [31:0] word;
  bit [2:0]  index;
  bit        is_final;
} digest_word_t;

// Tracks the hash state of the message in flight and the digest words still owed.
class digest_tracker;
  bit [31:0]    chain[5];
  bit [7:0]     blk[64];
  int unsigned  fill;
  bit [60:0]    nbytes;
  digest_word_t owed_words[$];
  int unsigned  errors;
  int unsigned  words_predicted;

  function new();
    int i;
    for (i = 0; i < 64; i++) blk[i] = 8'h00;
    errors = 0;
    words_predicted = 0;
    restart();
  endfunction

  // Back to the SHA-1 initial value with an empty message.
  function void restart();
    chain[0] = 32'h67452301;
    chain[1] = 32'hefcdab89;
    chain[2] = 32'h98badcfe;
    chain[3] = 32'h10325476;
    chain[4] = 32'hc3d2e1f0;
    fill = 0;
    nbytes = '0;
  endfunction

  function bit [31:0] rol(bit [31:0] v, int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  // Eighty rounds over the current block, folded into the chaining value.
  function void compress_block();
    bit [31:0] w[80];
    bit [31:0] a, b, c, d, e, f, k, t;
    int r;
    for (r = 0; r < 16; r++)
      w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
    for (r = 16; r < 80; r++)
      w[r] = rol(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    e = chain[4];
    for (r = 0; r < 80; r++) begin
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = 32'h5a827999;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = 32'h6ed9eba1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = 32'h8f1bbcdc;
      end else begin
        f = b ^ c ^ d;
        k = 32'hca62c1d6;
      end
      t = rol(a, 5) + f + e + k + w[r];
      e = d;
      d = c;
      c = rol(b, 30);
      b = a;
      a = t;
    end
    chain[0] += a;
    chain[1] += b;
    chain[2] += c;
    chain[3] += d;
    chain[4] += e;
  endfunction

  // Notes one accepted input word and queues the digest it completes, if any.
  function void take_item(bit [7:0] data, bit has_byte, bit is_last);
    bit [63:0]    bit_len;
    digest_word_t dw;
    int           i;
    if (has_byte) begin
      blk[fill] = data;
      fill++;
      nbytes = nbytes + 61'd1;
      if (fill == 64) begin
        compress_block();
        fill = 0;
      end
    end
    if (!is_last) return;

    // Padding: marker byte, zeros, then the bit length; a second block if it does not fit.
    bit_len = {nbytes, 3'b000};
    blk[fill] = 8'h80;
    fill++;
    if (fill > 56) begin
      while (fill < 64) begin
        blk[fill] = 8'h00;
        fill++;
      end
      compress_block();
      fill = 0;
    end
    while (fill < 56) begin
      blk[fill] = 8'h00;
      fill++;
    end
    for (i = 0; i < 8; i++) blk[63-i] = bit_len[8*i +: 8];
    compress_block();

    for (i = 0; i < 5; i++) begin
      dw.word = chain[i];
      dw.index = i[2:0];
      dw.is_final = (i[2:0] == sha1md_pkg::CV_LAST);
      owed_words.push_back(dw);
      words_predicted++;
    end
    restart();
  endfunction

  function int unsigned pending();
    return owed_words.size();
  endfunction

  task report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // Compares one accepted digest word with the oldest one owed.
  task check_word(bit [31:0] word, bit [2:0] index, bit is_final);
    digest_word_t want;
    if (owed_words.size() == 0) begin
      report_mismatch($sformatf("unexpected digest word %h index %0d", word, index));
    end else begin
      want = owed_words.pop_front();
      if (word !== want.word)
        report_mismatch($sformatf("digest word %0d got %h want %h", want.index, word,
                                  want.word));
      if (index !== want.index)
        report_mismatch($sformatf("word index got %0d want %0d", index, want.index));
      if (is_final !== want.is_final)
        report_mismatch($sformatf("final flag of word %0d got %b want %b", want.index,
                                  is_final, want.is_final));
    end
  endtask
endclass

module sha1_message_digest_core_test;
  import sha1md_pkg::*;

  localparam int unsigned STALL_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst_n;

  sha1md_in_if  in_ch();
  sha1md_out_if out_ch();

  sha1_message_digest_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  digest_tracker sb;
  int unsigned   sender_idle_pct = 18;
  int unsigned   sink_idle_pct = 75;
  int unsigned   items_sent = 0;
  int unsigned   quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sink side backpressure.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Every accepted digest word is checked against the prediction.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_word(out_ch.digest_word, out_ch.word_index, out_ch.final_word);
  end

  // Watchdog: the run ends if neither channel moves a word for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("[sha1_message_digest_core] ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Offers one word, with random idle cycles ahead of it, and waits until it is taken.
  task automatic send_item(input logic [7:0] data, input logic has_byte, input logic is_last);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= data;
    in_ch.byte_valid <= has_byte;
    in_ch.last       <= is_last;
    do @(posedge clk); while (!in_ch.ready);
    sb.take_item(data, has_byte, is_last);
    if (has_byte || is_last) items_sent++;
  endtask

  function automatic logic [7:0] pick_byte();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) return 8'h00;
    if (roll < 20) return 8'hff;
    return 8'($urandom);
  endfunction

  // One whole message of len bytes with occasional empty words mixed in.
  task automatic send_message(input int unsigned len);
    int unsigned i;
    bit          split_last;
    split_last = (len == 0) || ($urandom_range(1) == 1);
    for (i = 0; i < len; i++) begin
      if ($urandom_range(99) < 8) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(pick_byte(), 1'b1, (i == len - 1) && !split_last);
    end
    if (split_last) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  // Sender holds off until every owed digest word has come out.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned target;
    int unsigned roll;
    int          ph;

    sb = new();
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = 8'h00;
    in_ch.byte_valid = 1'b0;
    in_ch.last       = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty message, byte with last, empty words, extreme bytes, back-to-back ends.
    send_item(8'h5a, 1'b0, 1'b1);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b0, 1'b1);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hff, 1'b0, 1'b1);

    // Random: three idling profiles, each opened by lengths at the padding boundaries.
    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          sender_idle_pct = 18;
          sink_idle_pct = 75;
          send_message(55);
          send_message(56);
        end
        1: begin
          sender_idle_pct = 75;
          sink_idle_pct = 18;
          send_message(63);
          send_message(64);
        end
        default: begin
          sender_idle_pct = 0;
          sink_idle_pct = 0;
          send_message(57);
          send_message(120);
        end
      endcase
      target = (ph + 1) * 160;
      while (items_sent < target || (ph == 2 && sb.words_predicted < 60)) begin
        roll = $urandom_range(99);
        if (roll < 60) send_message($urandom_range(12));
        else if (roll < 90) send_message($urandom_range(50, 13));
        else send_message($urandom_range(70, 51));
      end
      drain();
    end

    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[sha1_message_digest_core] OK");
    end else begin
      $display("[sha1_message_digest_core] ERROR");
    end
    $finish;
  end
endmodule
